// ----- hw/rtl/kwmq_pkg.sv -----
// Package for the k-way merge minimum queue.
// Holds the stored entry type, the item kind codes and the entry ordering function.
// No dependencies.
package kwmq_pkg;

    // Item kinds carried on the input tuser bit
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // Fixed field widths
    localparam int VALUE_W  = 16;
    localparam int SOURCE_W = 4;

    // One stored entry: value and the index of its source list
    typedef struct packed {
        logic [SOURCE_W-1:0]       source;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    // Strict order: smaller value first, ties go to the smaller source index
    function automatic logic entry_less(entry_t a, entry_t b);
        logic value_lt;
        logic value_eq;
        value_lt = (a.value < b.value);
        value_eq = (a.value == b.value);
        return value_lt || (value_eq && (a.source < b.source));
    endfunction

endpackage

// ----- hw/rtl/kwmq_store.sv -----
// Entry storage of the merge queue: one write port, one read port with registered data.
// Depends on kwmq_pkg for entry_t.
module kwmq_store
    import kwmq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered: data appears in the cycle after the address
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/k_way_merge_min_queue.sv -----
// Minimum priority queue for a k-way merge of sorted streams.
// Input channel s_axis: tuser selects insert (0) or pop (1); tdata carries the
// value and its source list on insert and is ignored on pop.
// Output channel m_axis: one beat per pop with the removed minimum and its
// source list; tuser is set when the pop found the queue empty (tdata zero).
// Inserts give no output beat. An insert into a full queue is dropped.
// Equal values leave in order of smaller source index.
// Inserts may come every cycle while no pop is in work; s_axis_tready is low
// while a pop is being worked on. A pop on a non-empty queue passes from
// acceptance through the scan, move and output states to m_axis_tvalid: a
// single compare unit walks the entry memory one entry per cycle, then the last
// entry is moved into the freed slot. An empty pop goes straight to output.
// A result waiting on a stalled m_axis does not block inserts; a following
// pop scans and then waits until the output register is free.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending
// output beat; memory contents are not cleared and need no clearing pass.
// Depends on kwmq_pkg and kwmq_store.
module k_way_merge_min_queue
    import kwmq_pkg::*;
#(
    parameter int LIST_COUNT = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] value, [19:16] list_index, [23:20] zero
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] min_value, [19:16] min_source, [23:20] zero
    output logic        m_axis_tuser    // [0] was_empty
);

    localparam int IDX_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int OCC_W = $clog2(LIST_COUNT + 1);
    localparam logic [OCC_W-1:0] FULL_COUNT = OCC_W'(LIST_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_OUT
    } state_t;

    state_t            state_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    entry_t            best_entry_reg;
    logic              res_empty_reg;
    logic              m_valid_reg;
    entry_t            m_entry_reg;
    logic              m_empty_reg;

    entry_t            in_entry;
    logic              in_fire;
    logic              out_free;
    logic              full;
    logic [OCC_W-1:0]  occ_dec;
    logic [IDX_W-1:0]  last_idx;
    logic              scan_last;
    logic              take_new;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;

    // Input beat decode
    assign in_entry.value  = signed'(s_axis_tdata[15:0]);
    assign in_entry.source = s_axis_tdata[19:16];
    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign in_fire         = s_axis_tvalid && s_axis_tready;
    assign out_free        = !m_valid_reg || m_axis_tready;

    // Occupancy helpers
    assign full      = (occ_reg == FULL_COUNT);
    assign occ_dec   = occ_reg - OCC_W'(1);
    assign last_idx  = occ_dec[IDX_W-1:0];
    assign scan_last = (cmp_idx_reg == last_idx);

    // Shared compare unit: keep the first entry or any strictly smaller one
    assign take_new = (cmp_idx_reg == '0) || entry_less(rd_data, best_entry_reg);

    // Memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = occ_reg[IDX_W-1:0];
        wr_data = in_entry;
        rd_addr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                wr_en = in_fire && (s_axis_tuser == KIND_INSERT) && !full;
            end
            ST_SCAN:
            begin
                rd_addr = scan_last ? cmp_idx_reg : IDX_W'(cmp_idx_reg + IDX_W'(1));
            end
            ST_MOVE:
            begin
                // rd_data holds the last entry; it fills the freed slot
                wr_en   = 1'b1;
                wr_addr = best_idx_reg;
                wr_data = rd_data;
            end
            ST_OUT:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    kwmq_store #(
        .DEPTH  (LIST_COUNT),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer, occupancy and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            cmp_idx_reg    <= '0;
            best_idx_reg   <= '0;
            best_entry_reg <= '0;
            res_empty_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_entry_reg    <= '0;
            m_empty_reg    <= 1'b0;
        end
        else
        begin
            // The output state reloads the valid flag itself
            if (m_valid_reg && m_axis_tready && (state_reg != ST_OUT))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_axis_tuser == KIND_INSERT)
                        begin
                            if (!full)
                            begin
                                occ_reg <= occ_reg + OCC_W'(1);
                            end
                        end
                        else if (occ_reg == '0)
                        begin
                            best_entry_reg <= '0;
                            res_empty_reg  <= 1'b1;
                            state_reg      <= ST_OUT;
                        end
                        else
                        begin
                            cmp_idx_reg   <= '0;
                            res_empty_reg <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (take_new)
                    begin
                        best_entry_reg <= rd_data;
                        best_idx_reg   <= cmp_idx_reg;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_MOVE;
                    end
                    else
                    begin
                        cmp_idx_reg <= IDX_W'(cmp_idx_reg + IDX_W'(1));
                    end
                end
                ST_MOVE:
                begin
                    occ_reg   <= occ_dec;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_entry_reg <= best_entry_reg;
                        m_empty_reg <= res_empty_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output beat
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_entry_reg.source, m_entry_reg.value};
    assign m_axis_tuser  = m_empty_reg;

`ifndef SYNTHESIS
    // Occupancy never passes the queue depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_COUNT)
        else $error("occupancy beyond queue depth");

    // An accepted insert into a non-full queue grows it by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_axis_tuser == KIND_INSERT) && !full)
        |=> (occ_reg == $past(occ_reg) + OCC_W'(1)))
        else $error("insert did not store an entry");

    // The scan index stays inside the stored entries
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ({1'b0, cmp_idx_reg} < (OCC_W + 1)'(occ_reg)))
        else $error("scan index beyond occupancy");

    // An empty result carries zero data
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("empty pop result with nonzero data");

    // A pop on a non-empty queue removes exactly one entry
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |=> (occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("pop did not remove an entry");
`endif

endmodule
